>>> rtl/rqnt_pkg.sv
`default_nettype none

package rqnt_pkg;

    // APB register map, byte address = 4 * index
    localparam int unsigned APB_AW    = 5;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_QUANT_MULT  = 3'd0,
        REG_QUANT_SHIFT = 3'd1,
        REG_OUTPUT_ZERO = 3'd2,
        REG_ACT_MIN     = 3'd3,
        REG_ACT_MAX     = 3'd4
    } rqnt_reg_idx_t;

    localparam logic signed [31:0] RST_QUANT_MULT  = 32'sh4000_0000;
    localparam logic signed [5:0]  RST_QUANT_SHIFT = 6'sd0;
    localparam logic signed [7:0]  RST_OUTPUT_ZERO = 8'sd0;
    localparam logic signed [7:0]  RST_ACT_MIN     = -8'sd128;
    localparam logic signed [7:0]  RST_ACT_MAX     = 8'sd127;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    // rounding term of the doubling high multiply
    localparam logic signed [63:0] ROUND_HALF = 64'sh0000_0000_4000_0000;

    // right shifts of this size or more collapse to the sign
    localparam logic [5:0] RSH_SAT = 6'd31;

    typedef struct packed {
        logic signed [31:0] quant_multiplier;
        logic signed [5:0]  quant_shift;
        logic signed [7:0]  output_zero;
        logic signed [7:0]  act_min;
        logic signed [7:0]  act_max;
    } rqnt_cfg_t;

    typedef struct packed {
        logic signed [31:0] acc_value;
        logic               last_item;
    } rqnt_in_t;

    typedef struct packed {
        logic signed [7:0] requant_value;
        logic              last_out;
    } rqnt_out_t;

    // scaled value between the scale and finish halves
    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } rqnt_mid_t;

endpackage

`default_nettype wire

>>> rtl/rqnt_apb_regs.sv
`default_nettype none

module rqnt_apb_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rqnt_pkg::APB_AW-1:0]   paddr,
    input  wire logic [rqnt_pkg::APB_DW-1:0]   pwdata,
    output logic      [rqnt_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output rqnt_pkg::rqnt_cfg_t                cfg
);
    import rqnt_pkg::*;

    rqnt_cfg_t                cfg_reg;
    logic [REG_IDX_W-1:0]     reg_idx;
    logic                     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.quant_multiplier <= RST_QUANT_MULT;
            cfg_reg.quant_shift      <= RST_QUANT_SHIFT;
            cfg_reg.output_zero      <= RST_OUTPUT_ZERO;
            cfg_reg.act_min          <= RST_ACT_MIN;
            cfg_reg.act_max          <= RST_ACT_MAX;
        end else if (wr_en) begin
            case (reg_idx)
                REG_QUANT_MULT:  cfg_reg.quant_multiplier <= pwdata[31:0];
                REG_QUANT_SHIFT: cfg_reg.quant_shift      <= pwdata[5:0];
                REG_OUTPUT_ZERO: cfg_reg.output_zero      <= pwdata[7:0];
                REG_ACT_MIN:     cfg_reg.act_min          <= pwdata[7:0];
                REG_ACT_MAX:     cfg_reg.act_max          <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_QUANT_MULT:  prdata = cfg_reg.quant_multiplier;
            REG_QUANT_SHIFT: prdata = {26'd0, cfg_reg.quant_shift};
            REG_OUTPUT_ZERO: prdata = {24'd0, cfg_reg.output_zero};
            REG_ACT_MIN:     prdata = {24'd0, cfg_reg.act_min};
            REG_ACT_MAX:     prdata = {24'd0, cfg_reg.act_max};
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/rqnt_scale.sv
`default_nettype none

// stage 1: saturating left shift, stage 2: 32x32 multiply,
// stage 3: rounding and high-word pick
module rqnt_scale (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire rqnt_pkg::rqnt_cfg_t  cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire rqnt_pkg::rqnt_in_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output rqnt_pkg::rqnt_mid_t       out_data
);
    import rqnt_pkg::*;

    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                 s1_ready, s2_ready, s3_ready;
    logic signed [31:0]   s1_val_reg;
    logic                 s1_last_reg, s2_last_reg, s3_last_reg;
    logic signed [63:0]   s2_prod_reg;
    logic signed [31:0]   s3_val_reg;

    logic                 shl_en;
    logic [4:0]           shl_amt;
    logic [62:0]          shl_wide;
    logic signed [31:0]   s1_val_next;
    logic signed [63:0]   s2_prod_next;
    logic signed [63:0]   s3_sum;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // stage 1
    assign shl_en   = !cfg.quant_shift[5] && (|cfg.quant_shift[4:0]);
    assign shl_amt  = shl_en ? cfg.quant_shift[4:0] : 5'd0;
    assign shl_wide = {{31{in_data.acc_value[31]}}, in_data.acc_value} << shl_amt;

    always_comb begin
        if ((&shl_wide[62:31]) || !(|shl_wide[62:31])) begin
            s1_val_next = shl_wide[31:0];
        end else if (shl_wide[62]) begin
            s1_val_next = SAT_MIN;
        end else begin
            s1_val_next = SAT_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= in_valid;
        end
        if (s1_ready && in_valid) begin
            s1_val_reg  <= s1_val_next;
            s1_last_reg <= in_data.last_item;
        end
    end

    // stage 2
    assign s2_prod_next = s1_val_reg * cfg.quant_multiplier;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_prod_reg <= s2_prod_next;
            s2_last_reg <= s1_last_reg;
        end
    end

    // stage 3: round to nearest with ties toward plus infinity, computed as
    // floor((p + 2^30) / 2^31); the one overflow case wraps in 32 bits
    assign s3_sum = s2_prod_reg + ROUND_HALF;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_ready) begin
            s3_valid_reg <= s2_valid_reg;
        end
        if (s3_ready && s2_valid_reg) begin
            s3_val_reg  <= s3_sum[62:31];
            s3_last_reg <= s2_last_reg;
        end
    end

    assign out_valid      = s3_valid_reg;
    assign out_data.value = s3_val_reg;
    assign out_data.last  = s3_last_reg;

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s2_ready |=> s1_valid_reg && $stable(s1_val_reg))
        else $error("stage 1 beat changed while stalled");

    a_s2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg && !s3_ready |=> s2_valid_reg && $stable(s2_prod_reg))
        else $error("stage 2 product changed while stalled");

    a_in_take: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted beat not held in stage 1");

endmodule

`default_nettype wire

>>> rtl/rqnt_finish.sv
`default_nettype none

// stage 4: rounding right shift, stage 5: zero point and clamp
module rqnt_finish (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire rqnt_pkg::rqnt_cfg_t  cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire rqnt_pkg::rqnt_mid_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output rqnt_pkg::rqnt_out_t       out_data
);
    import rqnt_pkg::*;

    logic                 s4_valid_reg, s5_valid_reg;
    logic                 s4_ready, s5_ready;
    logic signed [31:0]   s4_val_reg;
    logic                 s4_last_reg, s5_last_reg;
    logic signed [7:0]    s5_val_reg;

    logic                 rsh_en;
    logic [5:0]           rsh_amt;
    logic [31:0]          rsh_mask;
    logic [31:0]          rsh_rem;
    logic [31:0]          rsh_thr;
    logic signed [31:0]   s4_val_next;

    logic signed [32:0]   zp_sum;
    logic signed [32:0]   clamp_lo;
    logic signed [32:0]   clamp_hi;
    logic signed [32:0]   clamp_val;

    assign s5_ready = !s5_valid_reg || out_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign in_ready = s4_ready;

    // stage 4
    assign rsh_en   = cfg.quant_shift[5];
    assign rsh_amt  = 6'(-cfg.quant_shift);
    assign rsh_mask = ~(32'hFFFF_FFFF << rsh_amt[4:0]);
    assign rsh_rem  = in_data.value & rsh_mask;
    assign rsh_thr  = (rsh_mask >> 1) + {31'd0, in_data.value[31]};

    always_comb begin
        if (!rsh_en) begin
            s4_val_next = in_data.value;
        end else if (rsh_amt >= RSH_SAT) begin
            s4_val_next = {32{in_data.value[31]}};
        end else begin
            // keep the sum signed so the shift stays arithmetic
            s4_val_next = (in_data.value >>> rsh_amt[4:0])
                        + $signed({31'd0, (rsh_rem > rsh_thr)});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (s4_ready) begin
            s4_valid_reg <= in_valid;
        end
        if (s4_ready && in_valid) begin
            s4_val_reg  <= s4_val_next;
            s4_last_reg <= in_data.last;
        end
    end

    // stage 5: lower bound first, upper bound wins when they cross
    assign zp_sum   = 33'(s4_val_reg) + 33'(cfg.output_zero);
    assign clamp_lo = 33'(cfg.act_min);
    assign clamp_hi = 33'(cfg.act_max);

    always_comb begin
        clamp_val = zp_sum;
        if (clamp_val < clamp_lo) begin
            clamp_val = clamp_lo;
        end
        if (clamp_val > clamp_hi) begin
            clamp_val = clamp_hi;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
        end else if (s5_ready) begin
            s5_valid_reg <= s4_valid_reg;
        end
        if (s5_ready && s4_valid_reg) begin
            s5_val_reg  <= clamp_val[7:0];
            s5_last_reg <= s4_last_reg;
        end
    end

    assign out_valid              = s5_valid_reg;
    assign out_data.requant_value = s5_val_reg;
    assign out_data.last_out      = s5_last_reg;

    a_s4_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s4_valid_reg && !s5_ready |=> s4_valid_reg && $stable(s4_val_reg)
                                      && $stable(s4_last_reg))
        else $error("stage 4 beat changed while stalled");

    a_s5_move: assert property (@(posedge aclk) disable iff (!aresetn)
        s4_valid_reg && s5_ready |=> s5_valid_reg)
        else $error("stage 4 beat lost on its way to the output");

endmodule

`default_nettype wire

>>> rtl/int32_to_int8_requantizer.sv
// Channel   Dir  Beat                 Handshake
// --------  ---  -------------------  -------------------------------
// s_        in   acc_value, last_item s_valid / s_ready
// m_        out  requant_value, last_out  m_valid / m_ready
// APB       in   5 config registers   psel / penable / pwrite, pready=1
//
// One beat per cycle sustained while m_ready stays high.
// The stages are: saturating shift, 32x32 multiply, rounding add, rounding
// right shift, zero point and clamp. Reset (aresetn low, synchronous) loads
// the register defaults and empties the pipe. Each stage holds its beat when
// the one after it is full and stalled, so a stall on m_ready loses nothing
// and bubbles close up behind it.
`default_nettype none

module int32_to_int8_requantizer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rqnt_pkg::APB_AW-1:0]   paddr,
    input  wire logic [rqnt_pkg::APB_DW-1:0]   pwdata,
    output logic      [rqnt_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire rqnt_pkg::rqnt_in_t            s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output rqnt_pkg::rqnt_out_t                m_data
);
    import rqnt_pkg::*;

    rqnt_cfg_t  cfg;
    rqnt_mid_t  mid_data;
    logic       mid_valid;
    logic       mid_ready;

    rqnt_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rqnt_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_data  (mid_data)
    );

    rqnt_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_data   (mid_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

`default_nettype wire

>>> sim/tb_int32_to_int8_requantizer.sv
`timescale 1ns / 100ps

module tb_int32_to_int8_requantizer;
    import rqnt_pkg::*;

    localparam int unsigned REG_COUNT    = 5;
    localparam int unsigned REG_SLOTS    = 1 << (APB_AW - 2);
    localparam int          STALL_LIMIT  = 1000;
    localparam int          RANDOM_PHASES = 24;

    localparam longint Q31_MAX  = 64'sd2147483647;
    localparam longint Q31_MIN  = -64'sd2147483648;
    localparam longint Q31_HALF = 64'sd1073741824;
    localparam longint Q32_WRAP = 64'sd4294967296;

    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    rqnt_in_t            s_data;
    logic                m_valid;
    logic                m_ready;
    rqnt_out_t           m_data;

    rqnt_cfg_t           cfg_shadow;
    rqnt_out_t           requant_q[$];
    rqnt_out_t           want_beat;
    int                  mismatch_count;
    int                  beats_checked;
    int                  quiet_cycles;
    int                  hold_cycles;
    bit                  steady;

    int32_to_int8_requantizer DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Predicted int8 result for one accumulator under the shadow config
    function automatic rqnt_out_t requantize(rqnt_in_t beat);
        longint    v;
        longint    prod;
        longint    adj;
        longint    mask;
        longint    rem;
        longint    thr;
        int        sh;
        rqnt_out_t r;
        v  = longint'(signed'(beat.acc_value));
        sh = int'(signed'(cfg_shadow.quant_shift));
        if (sh > 0) v = v <<< sh;
        if (v > Q31_MAX) v = Q31_MAX;
        if (v < Q31_MIN) v = Q31_MIN;
        prod = v * longint'(signed'(cfg_shadow.quant_multiplier));
        adj  = prod + ((prod >= 0) ? Q31_HALF : (64'sd1 - Q31_HALF));
        if (adj >= 0) v = adj >>> 31;
        else          v = -((-adj) >>> 31);
        // min * min rounds to 2^31 and wraps
        if (v > Q31_MAX) v = v - Q32_WRAP;
        if (sh < 0) begin
            sh = -sh;
            if (sh >= 31) begin
                v = (v < 0) ? -64'sd1 : 64'sd0;
            end else begin
                mask = (64'sd1 <<< sh) - 64'sd1;
                rem  = v & mask;
                thr  = (mask >>> 1) + ((v < 0) ? 64'sd1 : 64'sd0);
                v    = (v >>> sh) + ((rem > thr) ? 64'sd1 : 64'sd0);
            end
        end
        v = v + longint'(signed'(cfg_shadow.output_zero));
        if (v < longint'(signed'(cfg_shadow.act_min))) v = longint'(signed'(cfg_shadow.act_min));
        if (v > longint'(signed'(cfg_shadow.act_max))) v = longint'(signed'(cfg_shadow.act_max));
        r.requant_value = v[7:0];
        r.last_out      = beat.last_item;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("MISMATCH %s at result %0d: expected %0d, got %0d",
                 what, beats_checked, want, got);
        mismatch_count++;
    endtask

    // Scoreboard: predict on input beats, check output beats in order
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) requant_q.push_back(requantize(s_data));
            if (m_valid && m_ready) begin
                if (requant_q.size() == 0) begin
                    report_mismatch("output beat with nothing pending", 0,
                                    int'(signed'(m_data.requant_value)));
                end else begin
                    want_beat = requant_q.pop_front();
                    if (m_data.requant_value !== want_beat.requant_value)
                        report_mismatch("requant_value", int'(signed'(want_beat.requant_value)),
                                        int'(signed'(m_data.requant_value)));
                    if (m_data.last_out !== want_beat.last_out)
                        report_mismatch("last_out", int'(want_beat.last_out),
                                        int'(m_data.last_out));
                end
                beats_checked++;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else                                              quiet_cycles++;
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("stall: no beat moved for %0d cycles", STALL_LIMIT);
        $display("tb_int32_to_int8_requantizer failed");
        $finish;
    end

    // Output side: random back-pressure, ready held high in steady mode, plus a counted hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready = 1'b0;
                hold_cycles--;
            end else if (steady) begin
                m_ready = 1'b1;
            end else begin
                m_ready = ($urandom_range(99) >= 36);
            end
        end
    end

    task automatic send_acc(input logic [31:0] acc, input logic last);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 36) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_data.acc_value = acc;
        s_data.last_item = last;
        s_valid          = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (requant_q.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_write(input int unsigned idx, input logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_AW'(idx * 4);
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_QUANT_MULT:  cfg_shadow.quant_multiplier = value;
            REG_QUANT_SHIFT: cfg_shadow.quant_shift      = value[5:0];
            REG_OUTPUT_ZERO: cfg_shadow.output_zero      = value[7:0];
            REG_ACT_MIN:     cfg_shadow.act_min          = value[7:0];
            REG_ACT_MAX:     cfg_shadow.act_max          = value[7:0];
            default: ;  // unmapped slot, block ignores it
        endcase
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_config(input logic [31:0] mult, input logic [5:0] shift,
                              input logic [7:0] zp, input logic [7:0] lo,
                              input logic [7:0] hi);
        apb_write(REG_QUANT_MULT, mult);
        apb_write(REG_QUANT_SHIFT, 32'(signed'(shift)));
        apb_write(REG_OUTPUT_ZERO, 32'(signed'(zp)));
        apb_write(REG_ACT_MIN, 32'(signed'(lo)));
        apb_write(REG_ACT_MAX, 32'(signed'(hi)));
    endtask

    function automatic rqnt_cfg_t rand_config();
        rqnt_cfg_t c;
        case ($urandom_range(5))
            0:       c.quant_multiplier = SAT_MIN;
            1:       c.quant_multiplier = SAT_MAX;
            2:       c.quant_multiplier = '0;
            3:       c.quant_multiplier = $urandom;
            default: c.quant_multiplier = {2'b01, 30'($urandom)};
        endcase
        case ($urandom_range(7))
            0:       c.quant_shift = 6'b100000;   // -32
            1:       c.quant_shift = 6'(-31);
            2:       c.quant_shift = 6'(31);
            3:       c.quant_shift = 6'(int'($urandom_range(62)) - 31);
            default: c.quant_shift = 6'(int'($urandom_range(14)) - 12);
        endcase
        if ($urandom_range(3) == 0) c.output_zero = $urandom_range(1) ? 8'sd127 : -8'sd128;
        else                        c.output_zero = 8'($urandom);
        case ($urandom_range(3))
            0: begin
                c.act_min = -8'sd128;
                c.act_max = 8'sd127;
            end
            1: begin
                // may cross
                c.act_min = 8'($urandom);
                c.act_max = 8'($urandom);
            end
            default: begin
                c.act_min = 8'(-int'($urandom_range(128, 20)));
                c.act_max = 8'($urandom_range(127, 20));
            end
        endcase
        return c;
    endfunction

    function automatic logic [31:0] rand_acc();
        int k;
        k = $urandom_range(31, 1);
        case ($urandom_range(4))
            0, 1: return $urandom;
            2:    return 32'(signed'($urandom) >>> (32 - k));
            3:    return $urandom_range(1) ? (32'd1 << k) : -(32'd1 << k);
            default: begin
                case ($urandom_range(4))
                    0:       return SAT_MAX;
                    1:       return SAT_MIN;
                    2:       return '0;
                    3:       return '1;
                    default: return 32'd1;
                endcase
            end
        endcase
    endfunction

    task automatic apply_rand_config();
        rqnt_cfg_t c;
        c = rand_config();
        set_config(c.quant_multiplier, c.quant_shift, c.output_zero, c.act_min, c.act_max);
    endtask

    task automatic test_reset_defaults();
        send_acc(32'd0, 1'b0);
        send_acc(32'd1, 1'b1);
        send_acc('1, 1'b0);
        send_acc(SAT_MAX, 1'b1);
        send_acc(SAT_MIN, 1'b0);
        wait_drain();
    endtask

    task automatic test_corner_cases();
        // doubling high multiply of min by min overflows and wraps
        set_config(SAT_MIN, 6'd0, 8'sd127, -8'sd128, 8'sd127);
        send_acc(SAT_MIN, 1'b1);
        send_acc(SAT_MAX, 1'b0);
        send_acc(32'd0, 1'b1);
        wait_drain();
        // largest left shift saturates the accumulator
        set_config(SAT_MAX, 6'd31, 8'sd0, -8'sd128, 8'sd127);
        send_acc(32'd1, 1'b0);
        send_acc('1, 1'b1);
        wait_drain();
        // rounding at the half point, both signs
        set_config(SAT_MAX, 6'(-1), 8'sd0, -8'sd128, 8'sd127);
        send_acc(32'd3, 1'b0);
        send_acc(-32'sd3, 1'b1);
        wait_drain();
        // right shifts of 31 and 32 collapse to the sign
        set_config(SAT_MAX, 6'(-31), 8'sd0, -8'sd128, 8'sd127);
        send_acc(SAT_MAX, 1'b0);
        send_acc(SAT_MIN, 1'b1);
        wait_drain();
        set_config(SAT_MAX, 6'b100000, 8'sd0, -8'sd128, 8'sd127);
        send_acc(SAT_MAX, 1'b1);
        send_acc(SAT_MIN, 1'b0);
        wait_drain();
        // crossed clamp bounds: the max wins
        set_config(SAT_MAX, 6'd0, 8'sd0, 8'sd50, -8'sd20);
        send_acc(32'd1000, 1'b0);
        wait_drain();
        // zero point extremes
        set_config(32'd0, 6'd0, -8'sd128, -8'sd128, 8'sd127);
        send_acc(SAT_MAX, 1'b1);
        wait_drain();
        set_config(32'd0, 6'd0, 8'sd127, -8'sd128, 8'sd127);
        send_acc(SAT_MIN, 1'b0);
        wait_drain();
        // unmapped slots must leave the real registers alone
        for (int unsigned i = REG_COUNT; i < REG_SLOTS; i++) apb_write(i, '1);
        send_acc(32'd5, 1'b1);
        wait_drain();
    endtask

    task automatic test_random_phases();
        int n;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            apply_rand_config();
            n = $urandom_range(90, 40);
            for (int i = 0; i < n; i++) send_acc(rand_acc(), 1'($urandom));
            wait_drain();
        end
    endtask

    task automatic test_backpressure();
        apply_rand_config();
        hold_cycles = 80;
        for (int i = 0; i < 40; i++) send_acc(rand_acc(), 1'($urandom));
        // pause with beats in flight until all of them are out
        wait_drain();
        for (int i = 0; i < 40; i++) send_acc(rand_acc(), 1'($urandom));
        wait_drain();
    endtask

    task automatic test_full_rate();
        apply_rand_config();
        steady = 1'b1;
        for (int i = 0; i < 200; i++) send_acc(rand_acc(), 1'($urandom));
        wait_drain();
        steady = 1'b0;
    endtask

    initial begin
        aresetn          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        s_valid          = 1'b0;
        s_data           = '0;
        mismatch_count   = 0;
        beats_checked    = 0;
        quiet_cycles     = 0;
        hold_cycles      = 0;
        steady           = 1'b0;
        cfg_shadow.quant_multiplier = RST_QUANT_MULT;
        cfg_shadow.quant_shift      = RST_QUANT_SHIFT;
        cfg_shadow.output_zero      = RST_OUTPUT_ZERO;
        cfg_shadow.act_min          = RST_ACT_MIN;
        cfg_shadow.act_max          = RST_ACT_MAX;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_corner_cases();
        test_backpressure();
        test_full_rate();
        test_random_phases();

        wait_drain();
        repeat (20) @(posedge aclk);
        if (requant_q.size() != 0)
            report_mismatch("results never delivered", 0, requant_q.size());
        if (mismatch_count == 0) begin
            $display("tb_int32_to_int8_requantizer passed");
        end else begin
            $display("tb_int32_to_int8_requantizer failed");
        end
        $finish;
    end

endmodule
